>>> design/mftt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mftt_pkg
// Shared widths, register indexes and constants of the motor feedback turn
// tracker.
// ----------------------------------------------------------------------------
package mftt_pkg;

  localparam int DefNumMotors = 7;
  localparam int MaskBits     = 7;

  localparam int IdW     = 11;
  localparam int ByteW   = 8;
  localparam int IdxW    = 3;
  localparam int EncW    = 16;
  localparam int TurnW   = 16;
  localparam int AngleW  = 25;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 11;

  // packed stream widths, rounded up to whole bytes
  localparam int InDataW  = 72;
  localparam int OutDataW = 104;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ID_BASE     = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_ACCEPT_MASK = 1'd1;

  localparam logic [IdW-1:0]      ID_BASE_RESET     = 11'd513;
  localparam logic [MaskBits-1:0] ACCEPT_MASK_RESET = 7'd95;

  localparam logic signed [EncW:0]    JUMP_POS = 17'sd4096;
  localparam logic signed [EncW:0]    JUMP_NEG = -17'sd4096;
  localparam logic signed [TurnW-1:0] TURN_MAX = 16'sh7fff;
  localparam logic signed [TurnW-1:0] TURN_MIN = 16'sh8000;

  // output field offsets inside m_tdata
  localparam int OFS_IDX   = 0;
  localparam int OFS_ENC   = 3;
  localparam int OFS_SPEED = 19;
  localparam int OFS_CURR  = 35;
  localparam int OFS_TEMP  = 51;
  localparam int OFS_TURNS = 59;
  localparam int OFS_ANGLE = 75;

endpackage
`default_nettype wire

>>> design/motor_feedback_turn_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// motor_feedback_turn_tracker
// Decodes motor feedback frames and keeps a saturating multi-turn count and
// angle for each motor.
// ----------------------------------------------------------------------------
// Takes one frame per clock cycle while m_tready does not stall the result,
// passing each through the input register and then the result register.
// The per-motor encoder and turn stores are updated in the same
// cycle the result register loads, so a frame directly following one for the
// same motor already sees the new state. Frames whose identifier is below
// id_base, whose index is not below NUM_MOTORS or seven, or whose accept_mask
// bit is clear are dropped without a result and without touching state.
// Angle is turns*360 + encoder*360/8192 in degrees, truncated.
module motor_feedback_turn_tracker
  import mftt_pkg::*;
#(
  parameter int NUM_MOTORS = DefNumMotors
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // frame_id[10:0], byte0[18:11], byte1[26:19], byte2[34:27], byte3[42:35],
  // byte4[50:43], byte5[58:51], byte6[66:59], zero fill above
  input  wire logic [InDataW-1:0]  s_tdata,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // motor_index[2:0], encoder[18:3], speed[34:19], current[50:35],
  // temperature[58:51], turns[74:59], angle[99:75], zero fill above
  output logic [OutDataW-1:0]      m_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  localparam int Depth  = (NUM_MOTORS < MaskBits) ? NUM_MOTORS : MaskBits;
  localparam int SlotW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [IdW-1:0]      id_base;
  logic [MaskBits-1:0] accept_mask;

  logic                in_vld;
  logic [InDataW-1:0]  in_data;

  logic [EncW-1:0]         prev_enc [Depth];
  logic signed [TurnW-1:0] turn_cnt [Depth];

  logic                    out_free;
  logic                    fire;
  logic [IdW-1:0]          fid;
  logic [IdW-1:0]          idx;
  logic                    hit;
  logic [SlotW-1:0]        slot;
  logic [EncW-1:0]         enc;
  logic signed [EncW:0]    diff;
  logic signed [TurnW-1:0] turns_now;
  logic signed [TurnW-1:0] turns_next;
  logic signed [AngleW-1:0] angle;
  logic [AngleW-1:0]       enc_scaled;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      id_base     <= ID_BASE_RESET;
      accept_mask <= ACCEPT_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ID_BASE:     id_base     <= cfg_data[IdW-1:0];
        REG_ACCEPT_MASK: accept_mask <= cfg_data[MaskBits-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_vld && out_free;
  assign s_tready = !in_vld || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
    end
  end

  // decode and turn update
  assign fid  = in_data[IdW-1:0];
  assign idx  = fid - id_base;
  assign hit  = (fid >= id_base) && (idx < IdW'(Depth)) && accept_mask[idx[IdxW-1:0]];
  assign slot = idx[SlotW-1:0];
  assign enc  = {in_data[IdW+ByteW-1:IdW], in_data[IdW+2*ByteW-1:IdW+ByteW]};
  assign diff = $signed({1'b0, enc}) - $signed({1'b0, prev_enc[slot]});
  assign turns_now = turn_cnt[slot];

  always_comb begin
    turns_next = turns_now;
    if (diff > JUMP_POS) begin
      if (turns_now != TURN_MIN) turns_next = turns_now - 16'sd1;
    end else if (diff < JUMP_NEG) begin
      if (turns_now != TURN_MAX) turns_next = turns_now + 16'sd1;
    end
  end

  // turns*360 as shifts, encoder*360/8192 as a 16x9 product and a shift
  assign enc_scaled = (AngleW'(enc) * AngleW'(360)) >> 13;
  assign angle = (AngleW'(turns_next) <<< 8) + (AngleW'(turns_next) <<< 6)
               + (AngleW'(turns_next) <<< 5) + (AngleW'(turns_next) <<< 3)
               + $signed(enc_scaled);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) begin
        prev_enc[i] <= '0;
        turn_cnt[i] <= '0;
      end
    end else if (fire && hit) begin
      prev_enc[slot] <= enc;
      turn_cnt[slot] <= turns_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_vld && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hit) begin
      m_tdata <= {4'd0, angle, turns_next,
                  in_data[IdW+7*ByteW-1:IdW+6*ByteW],
                  in_data[IdW+5*ByteW-1:IdW+4*ByteW],
                  in_data[IdW+6*ByteW-1:IdW+5*ByteW],
                  in_data[IdW+3*ByteW-1:IdW+2*ByteW],
                  in_data[IdW+4*ByteW-1:IdW+3*ByteW],
                  enc, idx[IdxW-1:0]};
    end
  end

endmodule
`default_nettype wire

>>> design/mftt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mftt_checker
// Port-level checks on the result stream of the motor feedback turn tracker.
// ----------------------------------------------------------------------------
module mftt_checker
  import mftt_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic [OutDataW-1:0] m_tdata,
  input wire logic                m_tvalid,
  input wire logic                m_tready
);

  logic [IdxW-1:0]          chk_idx;
  logic [EncW-1:0]          chk_enc;
  logic signed [TurnW-1:0]  chk_turns;
  logic signed [AngleW-1:0] chk_angle;
  logic signed [AngleW-1:0] chk_expect;

  assign chk_idx    = m_tdata[OFS_IDX+IdxW-1:OFS_IDX];
  assign chk_enc    = m_tdata[OFS_ENC+EncW-1:OFS_ENC];
  assign chk_turns  = m_tdata[OFS_TURNS+TurnW-1:OFS_TURNS];
  assign chk_angle  = m_tdata[OFS_ANGLE+AngleW-1:OFS_ANGLE];
  // angle must agree with the turns and encoder it travels with
  assign chk_expect = AngleW'(chk_turns) * AngleW'(360)
                    + $signed((AngleW'(chk_enc) * AngleW'(360)) >> 13);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chk_idx != 3'd7)
    else $error("motor index out of range");

  a_angle_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chk_angle == chk_expect)
    else $error("angle does not match turns and encoder");

endmodule

bind motor_feedback_turn_tracker mftt_checker u_mftt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
`default_nettype wire
